// ===== rtl/tbcf_pkg.sv =====
`timescale 1ns / 1ps

package tbcf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned CAP_W   = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_req;
        logic [BYTE_W-1:0] wanted_type;
    } t_item;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [BYTE_W-1:0] found_length;
        logic [POS_W-1:0]  found_offset;
        logic [BYTE_W-1:0] entry_total;
    } t_result;

endpackage

// ===== rtl/tbcf_parser.sv =====
`timescale 1ns / 1ps

module tbcf_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  tbcf_pkg::t_item               i_item,
    input  logic [tbcf_pkg::CAP_W-1:0]    i_capacity,
    output logic                          o_emit,
    output tbcf_pkg::t_result             o_result
);
    import tbcf_pkg::*;

    logic              r_active, n_active;
    logic [BYTE_W-1:0] r_decl, n_decl;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_rem, n_rem;
    logic [BYTE_W-1:0] r_search, n_search;
    logic              r_cur_match, n_cur_match;
    logic              r_match_seen, n_match_seen;
    logic [BYTE_W-1:0] r_match_len, n_match_len;
    logic [POS_W-1:0]  r_match_off, n_match_off;
    logic [BYTE_W-1:0] r_entries, n_entries;

    logic              emit;
    logic              corrupt;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W:0]    end_sum;
    logic [BYTE_W-1:0] b;

    always_comb begin
        b            = i_item.data_byte;
        pos_inc      = r_pos + 1'b1;
        end_sum      = {1'b0, pos_inc} + {2'b00, b};
        n_active     = r_active;
        n_decl       = r_decl;
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_rem        = r_rem;
        n_search     = r_search;
        n_cur_match  = r_cur_match;
        n_match_seen = r_match_seen;
        n_match_len  = r_match_len;
        n_match_off  = r_match_off;
        n_entries    = r_entries;
        emit         = 1'b0;
        corrupt      = 1'b0;

        if (i_item.start_req) begin
            n_decl       = b;
            n_search     = i_item.wanted_type;
            n_pos        = '0;
            n_phase      = PH_TYPE;
            n_rem        = '0;
            n_cur_match  = 1'b0;
            n_match_seen = 1'b0;
            n_match_len  = '0;
            n_match_off  = '0;
            n_entries    = '0;
            n_active     = 1'b1;
            if ({1'b0, b} > i_capacity) begin
                emit    = 1'b1;
                corrupt = 1'b1;
            end else if (b == '0) begin
                emit = 1'b1;
            end
        end else if (r_active) begin
            n_pos = pos_inc;
            unique case (r_phase)
                PH_LEN: begin
                    if (end_sum > {2'b00, r_decl} || end_sum >= {1'b0, i_capacity}) begin
                        emit    = 1'b1;
                        corrupt = 1'b1;
                    end else begin
                        if (r_cur_match) begin
                            n_match_seen = 1'b1;
                            n_match_len  = b;
                            n_match_off  = pos_inc + 1'b1;
                        end
                        n_cur_match = 1'b0;
                        if (b == '0) begin
                            n_entries = r_entries + 1'b1;
                            n_phase   = PH_TYPE;
                        end else begin
                            n_rem   = b;
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    n_rem = r_rem - 1'b1;
                    if (n_rem == '0) begin
                        n_entries = r_entries + 1'b1;
                        n_phase   = PH_TYPE;
                    end
                end
                default: begin
                    n_cur_match = (b == r_search) && !r_match_seen;
                    n_phase     = PH_LEN;
                    if (pos_inc >= {1'b0, r_decl}) begin
                        emit    = 1'b1;
                        corrupt = 1'b1;
                    end
                end
            endcase
            if (!emit && pos_inc >= {1'b0, r_decl}) begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            n_active = 1'b0;
        end
    end

    always_comb begin
        o_emit                = emit;
        o_result.status       = corrupt;
        o_result.found        = !corrupt && n_match_seen;
        o_result.found_length = (!corrupt && n_match_seen) ? n_match_len : '0;
        o_result.found_offset = (!corrupt && n_match_seen) ? n_match_off : '0;
        o_result.entry_total  = n_entries;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_decl       <= '0;
            r_pos        <= '0;
            r_phase      <= PH_TYPE;
            r_rem        <= '0;
            r_search     <= '0;
            r_cur_match  <= 1'b0;
            r_match_seen <= 1'b0;
            r_match_len  <= '0;
            r_match_off  <= '0;
            r_entries    <= '0;
        end else if (i_adv) begin
            r_active     <= n_active;
            r_decl       <= n_decl;
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_rem        <= n_rem;
            r_search     <= n_search;
            r_cur_match  <= n_cur_match;
            r_match_seen <= n_match_seen;
            r_match_len  <= n_match_len;
            r_match_off  <= n_match_off;
            r_entries    <= n_entries;
        end
    end

endmodule

// ===== rtl/tlv_blob_check_and_find_core.sv =====
`timescale 1ns / 1ps

// TLV blob checker and finder.
// Input channel (i_in_valid / o_in_stall) carries one blob byte per word:
// i_start_req marks the length byte and samples i_wanted_type. Output channel
// (o_out_valid / i_out_stall) carries one result word per blob, given at the
// last declared byte or at the first framing error; bytes after that are
// dropped until the next start, and a new start abandons an open blob.
// Configuration: i_cfg_we writes i_cfg_data into the buffer capacity register
// (reset value 64); write it only while no blob is in flight.
// Throughput: one byte per cycle unless its result must wait for the
// occupied result register; the per-byte parse is one counter update and
// two bound compares between the input register and the result register.
// Reset (synchronous, active low) empties both registers and closes any blob.
// When the receiver stalls, the result register holds; the input register
// still advances bytes that make no result, and stalls the sender only when a
// second result would need the occupied result register.
module tlv_blob_check_and_find_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tbcf_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tbcf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_start_req,
    input  logic [tbcf_pkg::BYTE_W-1:0]   i_wanted_type,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic                          o_found,
    output logic [tbcf_pkg::BYTE_W-1:0]   o_found_length,
    output logic [tbcf_pkg::POS_W-1:0]    o_found_offset,
    output logic [tbcf_pkg::BYTE_W-1:0]   o_entry_total
);
    import tbcf_pkg::*;

    logic [CAP_W-1:0] r_capacity;

    // Input register
    logic             r_in_valid;
    t_item            r_item;

    // Result register
    logic             r_out_valid;
    t_result          r_result;

    logic             emit;
    t_result          result;
    logic             out_free;
    logic             adv;
    logic             in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    // Advance the held byte unless it makes a result that cannot be stored yet.
    assign adv        = r_in_valid && (!emit || out_free);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    tbcf_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (r_item),
        .i_capacity (r_capacity),
        .o_emit     (emit),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.data_byte   <= i_data_byte;
            r_item.start_req   <= i_start_req;
            r_item.wanted_type <= i_wanted_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_result.status;
    assign o_found        = r_result.found;
    assign o_found_length = r_result.found_length;
    assign o_found_offset = r_result.found_offset;
    assign o_entry_total  = r_result.entry_total;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tbcf_pkg::*;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // DUT ports driven by the bench
    logic                i_cfg_we = 1'b0;
    logic [CAP_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic [BYTE_W-1:0]   i_data_byte = '0;
    logic                i_start_req = 1'b0;
    logic [BYTE_W-1:0]   i_wanted_type = '0;
    logic                i_out_stall = 1'b0;

    // DUT outputs
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_status;
    logic                o_found;
    logic [BYTE_W-1:0]   o_found_length;
    logic [POS_W-1:0]    o_found_offset;
    logic [BYTE_W-1:0]   o_entry_total;

    tlv_blob_check_and_find_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_start_req    (i_start_req),
        .i_wanted_type  (i_wanted_type),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_found_length (o_found_length),
        .o_found_offset (o_found_offset),
        .o_entry_total  (o_entry_total)
    );

    // 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Parser shadow: a copy of the blob walk, advanced once per accepted
    // word, that predicts the result word each blob should produce.
    // ------------------------------------------------------------------
    logic [CAP_W-1:0]  cap_q = CAP_RESET;
    logic              open_q = 1'b0;
    logic [BYTE_W-1:0] blob_len_q = '0;
    logic [POS_W-1:0]  pos_q = '0;
    t_phase            phase_q = PH_TYPE;
    logic [BYTE_W-1:0] value_left_q = '0;
    logic [BYTE_W-1:0] search_q = '0;
    logic              type_hit_q = 1'b0;
    logic              hit_seen_q = 1'b0;
    logic [BYTE_W-1:0] hit_len_q = '0;
    logic [POS_W-1:0]  hit_off_q = '0;
    logic [BYTE_W-1:0] entries_q = '0;

    // Close the open blob and build its result word.
    function automatic t_result close_blob(input logic corrupted);
        t_result r;
        r.status = corrupted;
        if (corrupted || !hit_seen_q) begin
            r.found        = 1'b0;
            r.found_length = '0;
            r.found_offset = '0;
        end else begin
            r.found        = 1'b1;
            r.found_length = hit_len_q;
            r.found_offset = hit_off_q;
        end
        r.entry_total = entries_q;
        open_q = 1'b0;
        return r;
    endfunction

    // Advance the shadow by one word; return 1 when the word yields a result.
    function automatic logic blob_walk(input t_item w, output t_result r);
        int unsigned span;
        r = '0;
        if (w.start_req) begin
            // new blob: abandon whatever was open, sample the wanted type
            blob_len_q   = w.data_byte;
            search_q     = w.wanted_type;
            pos_q        = '0;
            phase_q      = PH_TYPE;
            value_left_q = '0;
            type_hit_q   = 1'b0;
            hit_seen_q   = 1'b0;
            hit_len_q    = '0;
            hit_off_q    = '0;
            entries_q    = '0;
            open_q       = 1'b1;
            if (w.data_byte > cap_q) begin
                r = close_blob(1'b1);
                return 1'b1;
            end
            if (w.data_byte == 0) begin
                r = close_blob(1'b0);
                return 1'b1;
            end
            return 1'b0;
        end

        // stray bytes with no open blob are dropped
        if (!open_q)
            return 1'b0;

        pos_q = pos_q + 1'b1;

        case (phase_q)
            PH_LEN: begin
                // entry must end inside the blob and inside the buffer
                span = int'(pos_q) + int'(w.data_byte);
                if (span > blob_len_q || span >= cap_q) begin
                    r = close_blob(1'b1);
                    return 1'b1;
                end
                if (type_hit_q) begin
                    hit_seen_q = 1'b1;
                    hit_len_q  = w.data_byte;
                    hit_off_q  = pos_q + 1'b1;
                end
                type_hit_q = 1'b0;
                if (w.data_byte == 0) begin
                    entries_q = entries_q + 1'b1;
                    phase_q   = PH_TYPE;
                end else begin
                    value_left_q = w.data_byte;
                    phase_q      = PH_VALUE;
                end
            end
            PH_VALUE: begin
                value_left_q = value_left_q - 1'b1;
                if (value_left_q == 0) begin
                    entries_q = entries_q + 1'b1;
                    phase_q   = PH_TYPE;
                end
            end
            default: begin
                // type byte; the unused phase code lands here as well
                type_hit_q = (w.data_byte == search_q) && !hit_seen_q;
                phase_q    = PH_LEN;
                // a type byte on the last declared byte has no length byte
                if (pos_q >= blob_len_q) begin
                    r = close_blob(1'b1);
                    return 1'b1;
                end
            end
        endcase

        if (pos_q >= blob_len_q) begin
            r = close_blob(1'b0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store and bookkeeping
    // ------------------------------------------------------------------
    t_item   pending_words[$];
    t_result blob_results[$];

    int queued_cnt = 0;
    int sent_cnt = 0;
    int blob_cnt = 0;
    int result_cnt = 0;
    int corrupt_cnt = 0;
    int match_cnt = 0;
    int err_cnt = 0;

    logic    word_taken = 1'b0;
    logic    hold_off = 1'b0;
    logic    quiet;
    t_item   next_word;
    t_item   seen_word;
    t_result pred_res;
    t_result got_res;
    t_result want_res;

    // no idling on either side through this window of the run
    assign quiet = (sent_cnt >= 350) && (sent_cnt < 500);

    task automatic push_word(input logic [7:0] b, input logic s, input logic [7:0] t);
        t_item w;
        w.data_byte   = b;
        w.start_req   = s;
        w.wanted_type = t;
        pending_words.push_back(w);
        queued_cnt++;
    endtask

    // Queue one blob: mostly well formed with random content, some cut
    // short, some with a bad length, some pure noise.
    task automatic add_blob(input int cap);
        int          pick;
        int          n;
        int          stop;
        int          pos;
        int          lmax;
        int          len;
        int          k;
        logic [7:0]  want;
        pick = $urandom_range(0, 15);
        blob_cnt++;
        if (pick == 3) begin
            // noise: random bytes, now and then a start
            repeat ($urandom_range(1, 12))
                push_word(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                          8'($urandom_range(0, 255)));
            return;
        end
        if (pick == 0)
            n = $urandom_range(25, 255);
        else if (pick == 1) begin
            // land near the capacity bound
            n = cap - 2 + $urandom_range(0, 3);
            if (n < 0)
                n = 0;
            if (n > 255)
                n = 255;
        end else
            n = $urandom_range(0, 24);
        stop = n;
        if (n > 1 && $urandom_range(0, 9) == 0)
            stop = $urandom_range(1, n - 1);
        want = 8'($urandom_range(0, 255));
        push_word(8'(n), 1'b1, want);
        pos = 0;
        while (pos < stop) begin
            pos++;
            push_word(($urandom_range(0, 2) == 0) ? want : 8'($urandom_range(0, 255)),
                      1'b0, 8'($urandom_range(0, 255)));
            if (pos >= stop)
                break;
            pos++;
            lmax = n - pos;
            if (lmax > 12)
                lmax = 12;
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(0, 255);
            else
                len = $urandom_range(0, lmax);
            push_word(8'(len), 1'b0, 8'($urandom_range(0, 255)));
            for (k = 0; k < len && pos < stop; k++) begin
                pos++;
                push_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
            end
        end
        // trailing bytes after the result must be dropped
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                push_word(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic fill_phase(input int cap);
        int base;
        int nb;
        base = queued_cnt;
        nb = 0;
        while (queued_cnt - base < 65 || nb < 3) begin
            add_blob(cap);
            nb++;
        end
    endtask

    // Hold until every queued word is taken and every result is back,
    // then let the pipe settle for words that make no result.
    task automatic drain;
        while (pending_words.size() != 0 || i_in_valid || blob_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_q = v;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next word at the falling edge; hold a stalled word.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
                next_word = pending_words.pop_front();
                i_in_valid    <= 1'b1;
                i_data_byte   <= next_word.data_byte;
                i_start_req   <= next_word.start_req;
                i_wanted_type <= next_word.wanted_type;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random outside the quiet window, and forced high during
    // the hold-off.
    always @(negedge i_clk) begin
        i_out_stall <= hold_off || (!quiet && $urandom_range(0, 99) < 11);
    end

    // Hold the receiver off long enough that the result register fills and
    // the block has to stall its input.
    initial begin
        while (sent_cnt < 60)
            @(negedge i_clk);
        hold_off = 1'b1;
        repeat (250) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predict on accepted input words and
    // check accepted result words against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_res.status       = o_status;
                got_res.found        = o_found;
                got_res.found_length = o_found_length;
                got_res.found_offset = o_found_offset;
                got_res.entry_total  = o_entry_total;
                if (blob_results.size() == 0) begin
                    $error("unexpected result word: status %0d found %0d len %0d off %0d total %0d",
                           o_status, o_found, o_found_length, o_found_offset, o_entry_total);
                    err_cnt++;
                end else begin
                    want_res = blob_results.pop_front();
                    result_cnt++;
                    if (want_res.status)
                        corrupt_cnt++;
                    if (want_res.found)
                        match_cnt++;
                    if (got_res.status !== want_res.status) begin
                        $error("status: expected %0d, got %0d", want_res.status, got_res.status);
                        err_cnt++;
                    end
                    if (got_res.found !== want_res.found) begin
                        $error("found: expected %0d, got %0d", want_res.found, got_res.found);
                        err_cnt++;
                    end
                    if (got_res.found_length !== want_res.found_length) begin
                        $error("found_length: expected %0d, got %0d",
                               want_res.found_length, got_res.found_length);
                        err_cnt++;
                    end
                    if (got_res.found_offset !== want_res.found_offset) begin
                        $error("found_offset: expected %0d, got %0d",
                               want_res.found_offset, got_res.found_offset);
                        err_cnt++;
                    end
                    if (got_res.entry_total !== want_res.entry_total) begin
                        $error("entry_total: expected %0d, got %0d",
                               want_res.entry_total, got_res.entry_total);
                        err_cnt++;
                    end
                end
            end

            word_taken = i_in_valid && !o_in_stall;
            if (word_taken) begin
                sent_cnt++;
                seen_word.data_byte   = i_data_byte;
                seen_word.start_req   = i_start_req;
                seen_word.wanted_type = i_wanted_type;
                if (blob_walk(seen_word, pred_res))
                    blob_results.push_back(pred_res);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed blobs, then random phases at several
    // buffer capacities.
    // ------------------------------------------------------------------
    initial begin
        int unsigned caps[7];
        int          i;
        caps[0] = 1;
        caps[1] = 0;
        caps[2] = 256;
        caps[3] = 511;
        caps[4] = 17;
        caps[5] = $urandom_range(2, 255);
        caps[6] = 64;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset capacity of 64
        push_word(8'hFF, 1'b0, 8'h00);          // stray byte, no blob open
        push_word(8'd0, 1'b1, 8'hFF);           // empty blob
        push_word(8'd65, 1'b1, 8'h00);          // length just past capacity
        push_word(8'd255, 1'b1, 8'hAA);         // largest length, past capacity
        push_word(8'd5, 1'b1, 8'd7);            // good blob, match on first entry
        push_word(8'd7, 1'b0, 8'h00);
        push_word(8'd1, 1'b0, 8'h00);
        push_word(8'hAA, 1'b0, 8'h00);
        push_word(8'd3, 1'b0, 8'h00);
        push_word(8'd0, 1'b0, 8'h00);
        push_word(8'h00, 1'b0, 8'hFF);          // trailing byte, dropped
        push_word(8'd3, 1'b1, 8'd0);            // entry runs past the blob
        push_word(8'd9, 1'b0, 8'h00);
        push_word(8'd5, 1'b0, 8'h00);
        push_word(8'd1, 1'b1, 8'd0);            // type byte on the last byte
        push_word(8'hFF, 1'b0, 8'h00);
        push_word(8'd10, 1'b1, 8'd1);           // abandoned by a restart
        push_word(8'd1, 1'b0, 8'h00);
        push_word(8'd2, 1'b1, 8'hFF);           // restart, zero-length match
        push_word(8'hFF, 1'b0, 8'h00);
        push_word(8'd0, 1'b0, 8'h00);
        push_word(8'd64, 1'b1, 8'd0);           // length equals capacity
        push_word(8'd0, 1'b0, 8'h00);
        push_word(8'd61, 1'b0, 8'h00);          // entry ends on the last buffer byte
        fill_phase(64);
        drain();

        for (i = 0; i < 7; i++) begin
            set_capacity(CAP_W'(caps[i]));
            fill_phase(caps[i]);
            drain();
        end

        repeat (10) @(negedge i_clk);
        $display("tb: %0d words sent in %0d blobs, %0d results (%0d corrupted, %0d matched)",
                 sent_cnt, blob_cnt, result_cnt, corrupt_cnt, match_cnt);
        $display("tb: capacities 64, 1, 0, 256, 511, 17, %0d and 64, with a long receiver hold-off",
                 caps[5]);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
